FILE: src/ppsb_pkg.sv
// Package for the ping-pong sample buffer: command codes, register index,
// status codes and the fixed field widths. It has no dependencies.
package ppsb_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned APB_W  = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

  // Register index, taken from paddr[2].
  localparam logic REG_BANK_LENGTH = 1'b0;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_SWAP   = 2'd3
  } cmd_t;

endpackage

FILE: src/ppsb_store.sv
// Single-port synchronous sample memory for the ping-pong sample buffer.
// One access per cycle, registered read data. No package dependency.
module ppsb_store #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/ping_pong_sample_buffer_top.sv
// Ping-pong sample buffer, top level. Uses ppsb_pkg and ppsb_store.
// Insert, query and swap results are registered in the cycle after the item is taken;
// a successful remove reads the word into the memory's read register, then ST_READ
// loads it into the result register. Throughput: one item per cycle while the result
// slot is free; ST_READ takes no item, set by the single port and its registered read.
// Reset (synchronous, rst_n low) clears the control state, then a clearing pass writes
// zero to all 2*BANK_DEPTH words, one per cycle; no item is taken during it.
module ping_pong_sample_buffer_top #(
  parameter int unsigned BANK_DEPTH = 256,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ppsb_pkg::CMD_W-1:0]   in_command,
  input  logic [ppsb_pkg::DATA_W-1:0]  in_write_data,
  input  logic [ppsb_pkg::LEN_W-1:0]   in_step,
  input  logic                         in_consume,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_status,
  output logic [ppsb_pkg::DATA_W-1:0]  out_read_data,
  output logic                         out_full_flag,
  output logic                         out_write_bank,
  output logic                         out_read_bank,

  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ppsb_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [ppsb_pkg::APB_W-1:0]   cfg_pwdata,
  output logic [ppsb_pkg::APB_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam int unsigned STORE_WORDS = 2 * BANK_DEPTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_WORDS);
  localparam int unsigned LEN_W       = ppsb_pkg::LEN_W;
  // Largest usable bank length: the register is 9 bits and is capped at BANK_DEPTH.
  localparam int unsigned LEN_MAX     = (1 << LEN_W) - 1;
  localparam int unsigned LEN_CAP     = (BANK_DEPTH < LEN_MAX) ? BANK_DEPTH : LEN_MAX;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_READ
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration register. The APB port never waits.
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] bank_length_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == ppsb_pkg::REG_BANK_LENGTH)
                    ? ppsb_pkg::APB_W'(bank_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_length_r <= ppsb_pkg::LEN_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == ppsb_pkg::REG_BANK_LENGTH)) begin
      bank_length_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Control state and result register.
  // ---------------------------------------------------------------------------
  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic                     wsel_r, wsel_nxt;
  logic [LEN_W-1:0]         put_r, put_nxt;
  logic [LEN_W-1:0]         get_r, get_nxt;
  logic                     full_r, full_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_status_r, out_status_nxt;
  logic [ppsb_pkg::DATA_W-1:0] out_rdata_r, out_rdata_nxt;
  logic                     out_full_r, out_full_nxt;
  logic                     out_wbank_r, out_wbank_nxt;

  // Item decode.
  ppsb_pkg::cmd_t           cmd;
  logic                     accept;
  logic                     out_free;
  logic [LEN_W-1:0]         len_eff;
  logic [LEN_W-1:0]         idx;
  logic [LEN_W-1:0]         idx_adv;
  logic                     fits;
  logic                     bank;
  logic [LEN_W:0]           addr_sum;
  logic                     do_swap;
  logic                     new_full;

  // Memory port.
  logic                     mem_en;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_addr;
  logic [WORD_BITS-1:0]     mem_wdata;
  logic [WORD_BITS-1:0]     mem_rdata;

  assign cmd = ppsb_pkg::cmd_t'(in_command);

  // The result slot can take a new result when it is empty or being emptied now.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_RUN) || !out_free;
  assign accept   = in_valid && !in_stall;

  // A bank length above BANK_DEPTH is used as BANK_DEPTH; zero leaves no room.
  assign len_eff = (bank_length_r > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : bank_length_r;

  // Inserts use the put index in the write bank, removes the get index in the
  // other bank. The step must be nonzero and fit in the room after the index.
  assign idx     = (cmd == ppsb_pkg::CMD_REMOVE) ? get_r : put_r;
  assign bank    = (cmd == ppsb_pkg::CMD_REMOVE) ? !wsel_r : wsel_r;
  assign fits    = (in_step != '0) && (idx < len_eff) && (in_step <= (len_eff - idx));
  assign idx_adv = idx + in_step;
  assign new_full = (idx_adv >= len_eff);

  // Word address is bank * length + index; it stays below 2 * length whenever the step fits.
  assign addr_sum = (bank ? {1'b0, len_eff} : '0) + {1'b0, idx};

  // A swap happens only while the full flag is raised.
  assign do_swap = full_r && ((cmd == ppsb_pkg::CMD_SWAP) ||
                              ((cmd == ppsb_pkg::CMD_QUERY) && in_consume));

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    wsel_nxt       = wsel_r;
    put_nxt        = put_r;
    get_nxt        = get_r;
    full_nxt       = full_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_rdata_nxt  = out_rdata_r;
    out_full_nxt   = out_full_r;
    out_wbank_nxt  = out_wbank_r;
    mem_en         = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = ADDR_W'(addr_sum);
    mem_wdata      = WORD_BITS'(in_write_data);

    unique case (state_r)
      ST_CLEAR: begin
        mem_en      = 1'b1;
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(STORE_WORDS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept) begin
          out_status_nxt = ppsb_pkg::STATUS_OK;
          out_rdata_nxt  = '0;
          out_full_nxt   = full_r;
          out_wbank_nxt  = wsel_r;
          out_valid_nxt  = 1'b1;
          case (cmd)
            ppsb_pkg::CMD_INSERT: begin
              if (fits) begin
                mem_en       = 1'b1;
                mem_we       = 1'b1;
                put_nxt      = idx_adv;
                full_nxt     = new_full;
                out_full_nxt = new_full;
              end else begin
                out_status_nxt = ppsb_pkg::STATUS_ERR;
              end
            end
            ppsb_pkg::CMD_REMOVE: begin
              if (fits) begin
                // The word arrives next cycle; the result waits for it.
                mem_en        = 1'b1;
                get_nxt       = idx_adv;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_READ;
              end else begin
                out_status_nxt = ppsb_pkg::STATUS_ERR;
              end
            end
            default: begin
              if (do_swap) begin
                full_nxt      = 1'b0;
                wsel_nxt      = !wsel_r;
                put_nxt       = '0;
                get_nxt       = '0;
                out_wbank_nxt = !wsel_r;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        // The slot was freed when the remove was taken and nothing else loads it.
        out_rdata_nxt = ppsb_pkg::DATA_W'(mem_rdata);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      wsel_r      <= 1'b0;
      put_r       <= '0;
      get_r       <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      wsel_r      <= wsel_nxt;
      put_r       <= put_nxt;
      get_r       <= get_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_full_r   <= out_full_nxt;
    out_wbank_r  <= out_wbank_nxt;
  end

  ppsb_store #(
    .DEPTH (STORE_WORDS),
    .WIDTH (WORD_BITS)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_data  = out_rdata_r;
  assign out_full_flag  = out_full_r;
  assign out_write_bank = out_wbank_r;
  assign out_read_bank  = !out_wbank_r;

endmodule
